>>> rtl/rrd_pkg.sv
package rrd_pkg;

    localparam int RRD_MAX_RESULTS = 4;
    localparam int RRD_QUEUE_DEPTH = 8;

    localparam logic [20:0] RST_MAX_LINE_LEN  = 21'd65536;
    localparam logic [30:0] RST_MAX_ARG_COUNT = 31'd1048576;
    localparam logic [30:0] RST_MAX_BULK_LEN  = 31'd536870912;

    localparam logic [1:0] CFG_MAX_LINE_LEN  = 2'd0;
    localparam logic [1:0] CFG_MAX_ARG_COUNT = 2'd1;
    localparam logic [1:0] CFG_MAX_BULK_LEN  = 2'd2;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [4:0] HEX_NONE  = 5'd16;

    localparam logic [63:0] NUM_PRE_LIMIT = 64'd922337203685477580;
    localparam logic [63:0] NUM_MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] NUM_POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INLINE_BIG   = 3'd1,
        ST_UNBALANCED   = 3'd2,
        ST_COUNT_BIG    = 3'd3,
        ST_BAD_COUNT    = 3'd4,
        ST_LENGTH_BIG   = 3'd5,
        ST_EXP_DOLLAR   = 3'd6,
        ST_BAD_LENGTH   = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_INLINE, PH_HDR, PH_HDR_STUCK, PH_BLEN, PH_BLEN_STUCK,
        PH_PAYLOAD, PH_TRAIL1, PH_TRAIL2
    } phase_t;

    typedef enum logic [3:0] {
        Q_IDLE, Q_PLAIN, Q_DQ, Q_DQ_ESC, Q_DQ_X, Q_DQ_XH, Q_SQ, Q_SQ_ESC,
        Q_AFTER, Q_FAIL, Q_IGNORE
    } qmode_t;

    typedef struct packed {
        logic [7:0]  arg_byte;
        logic        byte_valid;
        logic        arg_end;
        logic        cmd_done;
        logic [30:0] arg_total;
        status_t     status;
        logic        last;
    } res_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = HEX_NONE;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        return v;
    endfunction

    function automatic res_t mk_res(input logic [7:0] b, input logic v, input logic ae,
                                    input logic cd, input logic [30:0] tot,
                                    input status_t st);
        res_t r;
        r.arg_byte   = b;
        r.byte_valid = v;
        r.arg_end    = ae;
        r.cmd_done   = cd;
        r.arg_total  = tot;
        r.status     = st;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/rrd_core.sv
module rrd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  room,
    output logic [2:0]            push_cnt,
    output rrd_pkg::res_t [3:0]   push_data
);
    import rrd_pkg::*;

    logic [20:0] max_line_reg;
    logic [30:0] max_arg_reg, max_bulk_reg;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        proc;

    phase_t      phase_reg, phase_next;
    qmode_t      qm_reg, qm_next;
    logic [20:0] ll_reg, ll_next;
    logic [30:0] args_reg, args_next;
    logic [30:0] bulk_reg, bulk_next;
    logic [30:0] total_reg, total_next;
    logic [63:0] num_reg, num_next;
    logic [3:0]  nf_reg, nf_next;      // {bad, overflow, digit, sign}
    logic [7:0]  first_reg, first_next;
    logic [7:0]  held_reg, held_next;
    logic [20:0] icnt_reg, icnt_next;
    logic        halted_reg, halted_next;

    res_t [3:0]  res;
    logic [2:0]  n;

    assign proc     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= RST_MAX_LINE_LEN;
            max_arg_reg  <= RST_MAX_ARG_COUNT;
            max_bulk_reg <= RST_MAX_BULK_LEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LINE_LEN:  max_line_reg <= cfg_data[20:0];
                CFG_MAX_ARG_COUNT: max_arg_reg  <= cfg_data;
                CFG_MAX_BULK_LEN:  max_bulk_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            qm_reg     <= Q_IDLE;
            ll_reg     <= '0;
            args_reg   <= '0;
            bulk_reg   <= '0;
            total_reg  <= '0;
            num_reg    <= '0;
            nf_reg     <= '0;
            first_reg  <= '0;
            held_reg   <= '0;
            icnt_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            qm_reg     <= qm_next;
            ll_reg     <= ll_next;
            args_reg   <= args_next;
            bulk_reg   <= bulk_next;
            total_reg  <= total_next;
            num_reg    <= num_next;
            nf_reg     <= nf_next;
            first_reg  <= first_next;
            held_reg   <= held_next;
            icnt_reg   <= icnt_next;
            halted_reg <= halted_next;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic        do_inline, do_line, do_q, q_sq, plain_go, stuck, hdr, done;
        logic        neg, ok;
        logic [63:0] v10;
        logic [7:0]  esc;
        logic [4:0]  hb, hh;

        b = in_byte_reg;
        phase_next  = phase_reg;
        qm_next     = qm_reg;
        ll_next     = ll_reg;
        args_next   = args_reg;
        bulk_next   = bulk_reg;
        total_next  = total_reg;
        num_next    = num_reg;
        nf_next     = nf_reg;
        first_next  = first_reg;
        held_next   = held_reg;
        icnt_next   = icnt_reg;
        halted_next = halted_reg;
        res = '0;
        n   = '0;
        do_inline = 1'b0;
        do_line   = 1'b0;
        do_q      = 1'b0;
        q_sq      = 1'b0;
        plain_go  = 1'b0;
        stuck     = 1'b0;
        hdr       = 1'b0;
        done      = 1'b0;
        neg       = 1'b0;
        ok        = 1'b0;
        v10       = '0;
        esc       = b;
        hb        = hex_val(b);
        hh        = hex_val(held_reg);

        if (proc && !halted_reg)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (b == CH_STAR)
                    begin
                        phase_next = PH_HDR;
                        ll_next = '0; num_next = '0; nf_next = '0;
                        held_next = '0; first_next = '0;
                        do_line = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_INLINE;
                        ll_next = '0; qm_next = Q_IDLE; held_next = '0; icnt_next = '0;
                        do_inline = 1'b1;
                    end
                end
                PH_INLINE: do_inline = 1'b1;
                PH_HDR, PH_HDR_STUCK, PH_BLEN, PH_BLEN_STUCK: do_line = 1'b1;
                PH_PAYLOAD:
                begin
                    res[n[1:0]] = mk_res(b, 1'b1, 1'b0, 1'b0, '0, ST_OK); n = n + 3'd1;
                    bulk_next = bulk_reg - 31'd1;
                    if (bulk_next == '0) phase_next = PH_TRAIL1;
                end
                PH_TRAIL1: phase_next = PH_TRAIL2;
                PH_TRAIL2:
                begin
                    res[n[1:0]] = mk_res('0, 1'b0, 1'b1, 1'b0, '0, ST_OK); n = n + 3'd1;
                    args_next = args_reg - 31'd1;
                    if (args_next == '0)
                    begin
                        res[n[1:0]] = mk_res('0, 1'b0, 1'b0, 1'b1, total_reg, ST_OK);
                        n = n + 3'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_BLEN;
                        ll_next = '0; num_next = '0; nf_next = '0;
                        held_next = '0; first_next = '0;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase

            // Inline line: tokenizer on whitespace and quotes
            if (do_inline)
            begin
                if (b == CH_LF)
                begin
                    if (qm_next == Q_PLAIN || qm_next == Q_AFTER)
                    begin
                        icnt_next = icnt_next + 21'd1;
                        res[n[1:0]] = mk_res('0, 1'b0, 1'b1, 1'b0, '0, ST_OK); n = n + 3'd1;
                    end
                    if (qm_next != Q_PLAIN && qm_next != Q_AFTER && qm_next != Q_IDLE &&
                        qm_next != Q_IGNORE)
                    begin
                        halted_next = 1'b1;
                        res = '0;
                        res[0] = mk_res('0, 1'b0, 1'b0, 1'b0, '0, ST_UNBALANCED);
                        n = 3'd1;
                    end
                    else
                    begin
                        res[n[1:0]] = mk_res('0, 1'b0, 1'b0, 1'b1, {10'd0, icnt_next}, ST_OK);
                        n = n + 3'd1;
                        phase_next = PH_IDLE;
                    end
                end
                else if (ll_next >= max_line_reg)
                begin
                    halted_next = 1'b1;
                    res = '0;
                    res[0] = mk_res('0, 1'b0, 1'b0, 1'b0, '0, ST_INLINE_BIG);
                    n = 3'd1;
                end
                else
                begin
                    ll_next = ll_next + 21'd1;
                    case (qm_next)
                        Q_IDLE:
                        begin
                            if (is_space(b)) ;
                            else if (b == CH_NUL) qm_next = Q_IGNORE;
                            else
                            begin
                                qm_next = Q_PLAIN;
                                plain_go = 1'b1;
                            end
                        end
                        Q_PLAIN: plain_go = 1'b1;
                        Q_DQ: do_q = 1'b1;
                        Q_DQ_ESC:
                        begin
                            if (b == CH_NUL) qm_next = Q_FAIL;
                            else if (b == CH_X) qm_next = Q_DQ_X;
                            else
                            begin
                                case (b)
                                    8'h6E:   esc = 8'd10;
                                    8'h72:   esc = 8'd13;
                                    8'h74:   esc = 8'd9;
                                    8'h62:   esc = 8'd8;
                                    8'h61:   esc = 8'd7;
                                    default: esc = b;
                                endcase
                                res[n[1:0]] = mk_res(esc, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                                qm_next = Q_DQ;
                            end
                        end
                        Q_DQ_X:
                        begin
                            if (hb != HEX_NONE)
                            begin
                                held_next = b;
                                qm_next = Q_DQ_XH;
                            end
                            else
                            begin
                                res[n[1:0]] = mk_res(CH_X, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                                qm_next = Q_DQ;
                                do_q = 1'b1;
                            end
                        end
                        Q_DQ_XH:
                        begin
                            if (hb != HEX_NONE)
                            begin
                                res[n[1:0]] = mk_res({hh[3:0], hb[3:0]}, 1'b1, 1'b0, 1'b0,
                                                     '0, ST_OK);
                                n = n + 3'd1;
                                qm_next = Q_DQ;
                            end
                            else
                            begin
                                res[n[1:0]] = mk_res(CH_X, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                                res[n[1:0]] = mk_res(held_reg, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                                qm_next = Q_DQ;
                                do_q = 1'b1;
                            end
                        end
                        Q_SQ:
                        begin
                            do_q = 1'b1;
                            q_sq = 1'b1;
                        end
                        Q_SQ_ESC:
                        begin
                            qm_next = Q_SQ;
                            if (b == CH_SQUOTE)
                            begin
                                res[n[1:0]] = mk_res(CH_SQUOTE, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                            end
                            else
                            begin
                                res[n[1:0]] = mk_res(CH_BSLASH, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                                do_q = 1'b1;
                                q_sq = 1'b1;
                            end
                        end
                        Q_AFTER:
                        begin
                            if (is_space(b) || b == CH_NUL)
                            begin
                                icnt_next = icnt_next + 21'd1;
                                res[n[1:0]] = mk_res('0, 1'b0, 1'b1, 1'b0, '0, ST_OK);
                                n = n + 3'd1;
                                qm_next = (b == CH_NUL) ? Q_IGNORE : Q_IDLE;
                            end
                            else
                                qm_next = Q_FAIL;
                        end
                        default: ;
                    endcase

                    if (plain_go)
                    begin
                        if (b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_NUL)
                        begin
                            icnt_next = icnt_next + 21'd1;
                            res[n[1:0]] = mk_res('0, 1'b0, 1'b1, 1'b0, '0, ST_OK);
                            n = n + 3'd1;
                            qm_next = (b == CH_NUL) ? Q_IGNORE : Q_IDLE;
                        end
                        else if (b == CH_DQUOTE) qm_next = Q_DQ;
                        else if (b == CH_SQUOTE) qm_next = Q_SQ;
                        else
                        begin
                            res[n[1:0]] = mk_res(b, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                            n = n + 3'd1;
                        end
                    end

                    // Quoted byte: close, escape, fail on NUL or plain data
                    if (do_q)
                    begin
                        if (b == CH_NUL) qm_next = Q_FAIL;
                        else if (b == CH_BSLASH) qm_next = q_sq ? Q_SQ_ESC : Q_DQ_ESC;
                        else if (b == (q_sq ? CH_SQUOTE : CH_DQUOTE)) qm_next = Q_AFTER;
                        else
                        begin
                            res[n[1:0]] = mk_res(b, 1'b1, 1'b0, 1'b0, '0, ST_OK);
                            n = n + 3'd1;
                        end
                    end
                end
            end

            // Count or length line
            if (do_line)
            begin
                stuck = (phase_next == PH_HDR_STUCK) || (phase_next == PH_BLEN_STUCK);
                hdr   = (phase_next == PH_HDR) || (phase_next == PH_HDR_STUCK);
                if (!stuck && b == CH_LF)
                begin
                    if (ll_next >= 21'd1 && held_next[0])
                    begin
                        done = 1'b1;
                        neg = nf_next[0];
                        ok  = nf_next[1] && !nf_next[3] && !nf_next[2] &&
                              (neg || num_next <= NUM_POS_MAX);
                        if (hdr)
                        begin
                            if (!ok || (!neg && num_next > {33'd0, max_arg_reg}))
                            begin
                                halted_next = 1'b1;
                                res = '0;
                                res[0] = mk_res('0, 1'b0, 1'b0, 1'b0, '0, ST_BAD_COUNT);
                                n = 3'd1;
                            end
                            else if (neg || num_next == '0)
                            begin
                                res[n[1:0]] = mk_res('0, 1'b0, 1'b0, 1'b1, '0, ST_OK);
                                n = n + 3'd1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                args_next  = num_next[30:0];
                                total_next = num_next[30:0];
                                phase_next = PH_BLEN;
                                ll_next = '0; num_next = '0; nf_next = '0;
                                held_next = '0; first_next = '0;
                            end
                        end
                        else if (first_next != CH_DOLLAR)
                        begin
                            halted_next = 1'b1;
                            res = '0;
                            res[0] = mk_res('0, 1'b0, 1'b0, 1'b0, '0, ST_EXP_DOLLAR);
                            n = 3'd1;
                        end
                        else if (!ok || (neg && num_next != '0) ||
                                 num_next > {33'd0, max_bulk_reg})
                        begin
                            halted_next = 1'b1;
                            res = '0;
                            res[0] = mk_res('0, 1'b0, 1'b0, 1'b0, '0, ST_BAD_LENGTH);
                            n = 3'd1;
                        end
                        else
                        begin
                            bulk_next  = num_next[30:0];
                            phase_next = (num_next[30:0] != '0) ? PH_PAYLOAD : PH_TRAIL1;
                        end
                    end
                    else
                    begin
                        phase_next = hdr ? PH_HDR_STUCK : PH_BLEN_STUCK;
                        stuck = 1'b1;
                    end
                end
                if (!done)
                begin
                    if (ll_next >= max_line_reg)
                    begin
                        halted_next = 1'b1;
                        res = '0;
                        res[0] = mk_res('0, 1'b0, 1'b0, 1'b0, '0,
                                        hdr ? ST_COUNT_BIG : ST_LENGTH_BIG);
                        n = 3'd1;
                    end
                    else
                    begin
                        if (!stuck)
                        begin
                            if (ll_next == '0)
                                first_next = b;
                            else
                            begin
                                if (held_next[0] && ll_next >= 21'd2) nf_next[3] = 1'b1;
                                if (b != CH_CR)
                                begin
                                    if (b == CH_MINUS && ll_next == 21'd1)
                                        nf_next[0] = 1'b1;
                                    else if (b < 8'h30 || b > 8'h39)
                                        nf_next[3] = 1'b1;
                                    else
                                    begin
                                        nf_next[1] = 1'b1;
                                        if (!nf_next[2])
                                        begin
                                            if (num_next > NUM_PRE_LIMIT)
                                                nf_next[2] = 1'b1;
                                            else
                                            begin
                                                v10 = {num_next[60:0], 3'b000} +
                                                      {num_next[62:0], 1'b0} +
                                                      {60'd0, b[3:0]};
                                                num_next = v10;
                                                if (v10 > NUM_MAG_LIMIT) nf_next[2] = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end
                            held_next = (b == CH_CR) ? 8'd1 : 8'd0;
                        end
                        ll_next = ll_next + 21'd1;
                    end
                end
            end
        end

        if (n != '0)
            res[2'(n - 3'd1)].last = 1'b1;
        push_data = res;
        push_cnt  = proc ? n : 3'd0;
    end

endmodule

>>> rtl/rrd_queue.sv
module rrd_queue #(
    parameter int DEPTH = rrd_pkg::RRD_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [2:0]            push_cnt,
    input  rrd_pkg::res_t [3:0]   push_data,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rrd_pkg::res_t         head
);
    import rrd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;
    logic [PW:0]   slot [RRD_MAX_RESULTS];
    logic [PW:0]   wr_adv;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign room      = count_reg <= CW'(DEPTH - RRD_MAX_RESULTS);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        for (int k = 0; k < RRD_MAX_RESULTS; k++)
        begin
            slot[k] = {1'b0, wr_ptr_reg} + (PW+1)'(k);
            if (slot[k] >= (PW+1)'(DEPTH)) slot[k] = slot[k] - (PW+1)'(DEPTH);
        end
        wr_adv = {1'b0, wr_ptr_reg} + (PW+1)'(push_cnt);
        if (wr_adv >= (PW+1)'(DEPTH)) wr_adv = wr_adv - (PW+1)'(DEPTH);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RRD_MAX_RESULTS; k++)
            if (3'(k) < push_cnt)
                mem[slot[k][PW-1:0]] <= push_data[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_adv[PW-1:0];
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_reg + CW'(push_cnt) - CW'(pop);
        end
    end

endmodule

>>> rtl/resp_request_deframer.sv
// Request deframer: one raw request byte per input word, argument events out.
//
// Input channel  in_valid / in_ready / in_byte: the connection byte stream.
// Output channel out_valid / out_ready carries one event per word: a data
//   byte (byte_valid), an argument end (arg_end), a command end (cmd_done,
//   with arg_total) or an error (status nonzero). last marks the final word
//   caused by one input byte; a byte may cause none or up to three words.
// Config port cfg_we / cfg_index / cfg_data writes max_line_len (0),
//   max_arg_count (1) and max_bulk_len (2); write only while idle.
// Path: an accepted byte waits in the input register until the queue has room,
//   is parsed combinationally, and its words are written into the result queue,
//   whose head drives the output.
// Throughput: one byte per cycle while each byte yields at most one word and
//   out_ready is high; the result queue drains one word per cycle while
//   out_ready is high, which sets the long-run rate. in_ready is high while
//   the input register is empty or the queue has room for four words.
// Reset: limits return to defaults, parser goes idle, queue empties.
// Stall: with out_ready low the queue holds its words; once it lacks room for
//   another byte's worth, in_ready drops until words are taken.
// After any error word the parser drops all input until reset.
module resp_request_deframer #(
    parameter int QUEUE_DEPTH = rrd_pkg::RRD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  arg_byte,
    output logic        byte_valid,
    output logic        arg_end,
    output logic        cmd_done,
    output logic [30:0] arg_total,
    output logic [2:0]  status,
    output logic        last
);
    import rrd_pkg::*;

    logic        room;
    logic [2:0]  push_cnt;
    res_t [3:0]  push_data;
    res_t        head;

    // Parser: input register, state and per-byte event build
    rrd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .room      (room),
        .push_cnt  (push_cnt),
        .push_data (push_data)
    );

    // Result queue: takes up to four words a cycle, hands out one
    rrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign arg_byte   = head.arg_byte;
    assign byte_valid = head.byte_valid;
    assign arg_end    = head.arg_end;
    assign cmd_done   = head.cmd_done;
    assign arg_total  = head.arg_total;
    assign status     = head.status;
    assign last       = head.last;

endmodule

>>> rtl/rrd_checker.sv
module rrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  arg_byte,
    input logic        byte_valid,
    input logic        arg_end,
    input logic        cmd_done,
    input logic [30:0] arg_total,
    input logic [2:0]  status,
    input logic        last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(arg_byte) && $stable(status))
        else $error("stalled word changed");

    a_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !arg_end && !cmd_done && status == 3'd0)
        else $error("data word carries other events");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 3'd0 || cmd_done) |-> last)
        else $error("command end or error not last word of byte");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arg_total != '0 |-> cmd_done)
        else $error("argument total outside command end");

endmodule

bind resp_request_deframer rrd_checker u_rrd_checker (.*);

>>> bench/tb_resp_request_deframer.sv
`timescale 1ns / 100ps

module tb_resp_request_deframer;
    import rrd_pkg::*;

    // Parser state kept by the bench, snapshot-able so that candidate
    // commands can be tried and withdrawn.
    typedef struct {
        logic [31:0] lim_line;
        logic [31:0] lim_args;
        logic [31:0] lim_bulk;
        phase_t      ph;
        logic [31:0] llen;
        logic [30:0] args_left;
        logic [30:0] bulk_left;
        logic [63:0] num;
        logic [3:0]  nflags;
        logic [7:0]  first_b;
        qmode_t      qm;
        logic [15:0] held;
        logic [20:0] inl_count;
        logic        halted;
        logic [30:0] cmd_total;
    } parser_t;

    localparam logic [3:0] NF_SIGN  = 4'd1;
    localparam logic [3:0] NF_DIGIT = 4'd2;
    localparam logic [3:0] NF_OVF   = 4'd4;
    localparam logic [3:0] NF_BAD   = 4'd8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  arg_byte;
    logic        byte_valid;
    logic        arg_end;
    logic        cmd_done;
    logic [30:0] arg_total;
    logic [2:0]  status;
    logic        last;

    parser_t     ps;
    res_t        step_words[$];   // words caused by the byte being predicted
    res_t        trial_words[$];  // words of the candidate command
    res_t        expected_words[$];
    logic [7:0]  cand[$];         // candidate command bytes
    logic [7:0]  pending_bytes[$];
    logic        in_fire;
    int          bytes_sent;
    int          mismatches;
    logic        no_idle;

    resp_request_deframer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .arg_byte(arg_byte), .byte_valid(byte_valid), .arg_end(arg_end),
        .cmd_done(cmd_done), .arg_total(arg_total), .status(status), .last(last)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor of the parser
    // ---------------------------------------------------------------
    function automatic void put_word(logic [7:0] b, logic v, logic ae, logic cd,
                                     logic [30:0] tot, status_t st);
        res_t r;
        r.arg_byte   = b;
        r.byte_valid = v;
        r.arg_end    = ae;
        r.cmd_done   = cd;
        r.arg_total  = tot;
        r.status     = st;
        r.last       = 1'b0;
        if (step_words.size() < RRD_MAX_RESULTS)
            step_words = {step_words, r};
    endfunction

    function automatic void raise_error(status_t st);
        ps.halted = 1'b1;
        step_words.delete();
        put_word(8'd0, 1'b0, 1'b0, 1'b0, 31'd0, st);
    endfunction

    function automatic void emit_data(logic [7:0] b);
        put_word(b, 1'b1, 1'b0, 1'b0, 31'd0, ST_OK);
    endfunction

    function automatic void close_inline_arg();
        ps.inl_count = ps.inl_count + 21'd1;
        put_word(8'd0, 1'b0, 1'b1, 1'b0, 31'd0, ST_OK);
    endfunction

    function automatic logic white(logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [4:0] hexdigit(logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
        return HEX_NONE;
    endfunction

    function automatic void begin_line(phase_t ph);
        ps.ph      = ph;
        ps.llen    = 0;
        ps.num     = 64'd0;
        ps.nflags  = 4'd0;
        ps.held    = 16'd0;
        ps.first_b = 8'd0;
    endfunction

    function automatic void dquote_char(logic [7:0] b);
        if (b == CH_NUL) ps.qm = Q_FAIL;
        else if (b == CH_BSLASH) ps.qm = Q_DQ_ESC;
        else if (b == CH_DQUOTE) ps.qm = Q_AFTER;
        else emit_data(b);
    endfunction

    function automatic void squote_char(logic [7:0] b);
        if (b == CH_NUL) ps.qm = Q_FAIL;
        else if (b == CH_BSLASH) ps.qm = Q_SQ_ESC;
        else if (b == CH_SQUOTE) ps.qm = Q_AFTER;
        else emit_data(b);
    endfunction

    function automatic void plain_char(logic [7:0] b);
        if (b == CH_SPACE || b == CH_CR || b == CH_TAB) begin
            close_inline_arg();
            ps.qm = Q_IDLE;
        end
        else if (b == CH_NUL) begin
            close_inline_arg();
            ps.qm = Q_IGNORE;
        end
        else if (b == CH_DQUOTE) ps.qm = Q_DQ;
        else if (b == CH_SQUOTE) ps.qm = Q_SQ;
        else emit_data(b);
    endfunction

    function automatic void token_char(logic [7:0] b);
        logic [7:0] c;
        case (ps.qm)
            Q_IDLE: begin
                if (white(b)) return;
                if (b == CH_NUL) begin
                    ps.qm = Q_IGNORE;
                    return;
                end
                ps.qm = Q_PLAIN;
                plain_char(b);
            end
            Q_PLAIN: plain_char(b);
            Q_DQ: dquote_char(b);
            Q_DQ_ESC: begin
                if (b == CH_NUL) ps.qm = Q_FAIL;
                else if (b == CH_X) ps.qm = Q_DQ_X;
                else begin
                    c = b;
                    if (b == "n") c = 8'd10;
                    else if (b == "r") c = 8'd13;
                    else if (b == "t") c = 8'd9;
                    else if (b == "b") c = 8'd8;
                    else if (b == "a") c = 8'd7;
                    emit_data(c);
                    ps.qm = Q_DQ;
                end
            end
            Q_DQ_X: begin
                if (hexdigit(b) != HEX_NONE) begin
                    ps.held = {8'd0, b};
                    ps.qm = Q_DQ_XH;
                end
                else begin
                    emit_data(CH_X);
                    ps.qm = Q_DQ;
                    dquote_char(b);
                end
            end
            Q_DQ_XH: begin
                if (hexdigit(b) != HEX_NONE) begin
                    emit_data(8'(hexdigit(ps.held[7:0]) * 16 + hexdigit(b)));
                    ps.qm = Q_DQ;
                end
                else begin
                    emit_data(CH_X);
                    emit_data(ps.held[7:0]);
                    ps.qm = Q_DQ;
                    dquote_char(b);
                end
            end
            Q_SQ: squote_char(b);
            Q_SQ_ESC: begin
                ps.qm = Q_SQ;
                if (b == CH_SQUOTE) emit_data(CH_SQUOTE);
                else begin
                    emit_data(CH_BSLASH);
                    squote_char(b);
                end
            end
            Q_AFTER: begin
                if (white(b)) begin
                    close_inline_arg();
                    ps.qm = Q_IDLE;
                end
                else if (b == CH_NUL) begin
                    close_inline_arg();
                    ps.qm = Q_IGNORE;
                end
                else ps.qm = Q_FAIL;
            end
            default: ;
        endcase
    endfunction

    function automatic void inline_step(logic [7:0] b);
        if (b == CH_LF) begin
            if (ps.qm == Q_PLAIN || ps.qm == Q_AFTER) close_inline_arg();
            else if (ps.qm != Q_IDLE && ps.qm != Q_IGNORE) begin
                raise_error(ST_UNBALANCED);
                return;
            end
            put_word(8'd0, 1'b0, 1'b0, 1'b1, {10'd0, ps.inl_count}, ST_OK);
            ps.ph = PH_IDLE;
            return;
        end
        if (ps.llen >= ps.lim_line) begin
            raise_error(ST_INLINE_BIG);
            return;
        end
        ps.llen = ps.llen + 1;
        token_char(b);
    endfunction

    function automatic void number_digit(logic [7:0] b, logic [31:0] pos);
        if (b == CH_MINUS && pos == 1) begin
            ps.nflags |= NF_SIGN;
            return;
        end
        if (b < "0" || b > "9") begin
            ps.nflags |= NF_BAD;
            return;
        end
        ps.nflags |= NF_DIGIT;
        if (ps.nflags & NF_OVF) return;
        if (ps.num > NUM_PRE_LIMIT) begin
            ps.nflags |= NF_OVF;
            return;
        end
        ps.num = ps.num * 64'd10 + 64'(b - "0");
        if (ps.num > NUM_MAG_LIMIT) ps.nflags |= NF_OVF;
    endfunction

    function automatic void number_line_done();
        logic neg;
        logic ok;
        neg = (ps.nflags & NF_SIGN) != 0;
        ok = ((ps.nflags & NF_DIGIT) != 0) && ((ps.nflags & (NF_BAD | NF_OVF)) == 0) &&
             (neg || ps.num <= NUM_POS_MAX);
        if (ps.ph == PH_HDR) begin
            if (!ok || (!neg && ps.num > 64'(ps.lim_args))) begin
                raise_error(ST_BAD_COUNT);
                return;
            end
            if (neg || ps.num == 0) begin
                put_word(8'd0, 1'b0, 1'b0, 1'b1, 31'd0, ST_OK);
                ps.ph = PH_IDLE;
                return;
            end
            ps.args_left = ps.num[30:0];
            ps.cmd_total = ps.num[30:0];
            begin_line(PH_BLEN);
            return;
        end
        if (ps.first_b != CH_DOLLAR) begin
            raise_error(ST_EXP_DOLLAR);
            return;
        end
        if (!ok || (neg && ps.num != 0) || ps.num > 64'(ps.lim_bulk)) begin
            raise_error(ST_BAD_LENGTH);
            return;
        end
        ps.bulk_left = ps.num[30:0];
        ps.ph = (ps.bulk_left != 0) ? PH_PAYLOAD : PH_TRAIL1;
    endfunction

    function automatic void number_line_step(logic [7:0] b);
        logic stuck;
        logic hdr;
        stuck = (ps.ph == PH_HDR_STUCK || ps.ph == PH_BLEN_STUCK);
        hdr = (ps.ph == PH_HDR || ps.ph == PH_HDR_STUCK);
        if (!stuck && b == CH_LF) begin
            if (ps.llen >= 1 && ps.held[0]) begin
                number_line_done();
                return;
            end
            // bare LF: the line can no longer complete
            if (hdr) ps.ph = PH_HDR_STUCK;
            else ps.ph = PH_BLEN_STUCK;
            stuck = 1'b1;
        end
        if (ps.llen >= ps.lim_line) begin
            if (hdr) raise_error(ST_COUNT_BIG);
            else raise_error(ST_LENGTH_BIG);
            return;
        end
        if (!stuck) begin
            if (ps.llen == 0) ps.first_b = b;
            else begin
                if (ps.held[0] && ps.llen >= 2) ps.nflags |= NF_BAD;
                if (b != CH_CR) number_digit(b, ps.llen);
            end
            ps.held = (b == CH_CR) ? 16'd1 : 16'd0;
        end
        ps.llen = ps.llen + 1;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        step_words.delete();
        if (ps.halted) return;
        case (ps.ph)
            PH_IDLE: begin
                if (b == CH_STAR) begin
                    begin_line(PH_HDR);
                    number_line_step(b);
                end
                else begin
                    ps.ph = PH_INLINE;
                    ps.llen = 0;
                    ps.qm = Q_IDLE;
                    ps.held = 16'd0;
                    ps.inl_count = 21'd0;
                    inline_step(b);
                end
            end
            PH_INLINE: inline_step(b);
            PH_HDR, PH_HDR_STUCK, PH_BLEN, PH_BLEN_STUCK: number_line_step(b);
            PH_PAYLOAD: begin
                emit_data(b);
                ps.bulk_left = ps.bulk_left - 31'd1;
                if (ps.bulk_left == 0) ps.ph = PH_TRAIL1;
            end
            PH_TRAIL1: ps.ph = PH_TRAIL2;
            PH_TRAIL2: begin
                put_word(8'd0, 1'b0, 1'b1, 1'b0, 31'd0, ST_OK);
                ps.args_left = ps.args_left - 31'd1;
                if (ps.args_left == 0) begin
                    put_word(8'd0, 1'b0, 1'b0, 1'b1, ps.cmd_total, ST_OK);
                    ps.ph = PH_IDLE;
                end
                else begin_line(PH_BLEN);
            end
            default: ps.ph = PH_IDLE;
        endcase
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
        trial_words = {trial_words, step_words};
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        cand = {cand, b};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // Try the candidate on the predictor. With strict set, withdraw it unless
    // it leaves the parser idle and error-free; otherwise queue it for the
    // driver together with its expected words.
    function automatic bit submit_cmd(bit strict);
        parser_t keep;
        keep = ps;
        trial_words.delete();
        foreach (cand[i]) parse_byte(cand[i]);
        if (strict && (ps.halted || ps.ph != PH_IDLE)) begin
            ps = keep;
            cand.delete();
            return 1'b0;
        end
        pending_bytes = {pending_bytes, cand};
        expected_words = {expected_words, trial_words};
        cand.delete();
        return 1'b1;
    endfunction

    function automatic void send_text(string s);
        add_text(s);
        void'(submit_cmd(1'b0));
    endfunction

    function automatic void build_multibulk();
        int n;
        int len;
        n = $urandom_range(1, 4);
        if ($urandom_range(9) == 0) add_text($sformatf("*-%0d\r\n", $urandom_range(0, 9)));
        else add_text($sformatf("*%0d\r\n", n));
        for (int a = 0; a < n; a++) begin
            len = $urandom_range(0, 6);
            add_text($sformatf("$%0d\r\n", len));
            for (int k = 0; k < len + 2; k++) add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_inline();
        string plain_set;
        string hex_set;
        int n;
        plain_set = "abcXYZ019-_:";
        hex_set = "0123456789abcdefABCDEFgz";
        n = $urandom_range(1, 3);
        for (int t = 0; t < n; t++) begin
            if (t > 0) begin
                case ($urandom_range(2))
                    0: add_text(" ");
                    1: add_text("\t");
                    default: add_text("  ");
                endcase
            end
            case ($urandom_range(3))
                2: begin
                    add_text("\"");
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(9))
                            0: add_text(" ");
                            1: add_text("\\n");
                            2: add_text("\\r");
                            3: add_text("\\t");
                            4: begin
                                add_text("\\b");
                                add_text("\\a");
                            end
                            5: begin
                                add_text("\\x");
                                add_byte(hex_set[$urandom_range(0, hex_set.len() - 1)]);
                                add_byte(hex_set[$urandom_range(0, hex_set.len() - 1)]);
                            end
                            6: add_text("\\\"");
                            7: add_text("\\q");
                            default: add_byte(plain_set[$urandom_range(0, 11)]);
                        endcase
                    end
                    add_text("\"");
                end
                3: begin
                    add_text("'");
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(3))
                            0: add_text("\\'");
                            1: add_text("\\z");
                            2: add_text(" ");
                            default: add_byte(plain_set[$urandom_range(0, 11)]);
                        endcase
                    end
                    add_text("'");
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        add_byte(plain_set[$urandom_range(0, 11)]);
                end
            endcase
        end
        case ($urandom_range(2))
            0: add_text("\r\n");
            1: add_text("\n");
            default: add_text(" \n");
        endcase
    endfunction

    // Mostly well-formed commands with random content, the rest noise;
    // anything that would error out or leave a line open is withdrawn.
    task automatic random_traffic(int nbytes);
        int count;
        int tries;
        int before_sz;
        count = 0;
        tries = 0;
        while (count < nbytes && tries < 5000) begin
            tries++;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: build_multibulk();
                6, 7, 8: build_inline();
                default: begin
                    repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
                    add_text("\n");
                end
            endcase
            before_sz = pending_bytes.size();
            if (submit_cmd(1'b1)) count += pending_bytes.size() - before_sz;
        end
    endtask

    // Hold until every queued byte has been sent and every expected word
    // has come back.
    task automatic drain_all();
        while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MAX_LINE_LEN) ps.lim_line = {11'd0, val[20:0]};
        else if (idx == CFG_MAX_ARG_COUNT) ps.lim_args = {1'b0, val};
        else if (idx == CFG_MAX_BULK_LEN) ps.lim_bulk = {1'b0, val};
    endtask

    // ---------------------------------------------------------------
    // Driver: present words at the falling edge, hold until accepted
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_fire    <= 1'b0;
            bytes_sent <= 0;
        end
        else begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready) bytes_sent <= bytes_sent + 1;
        end
    end

    // a long burst with no idling on either side
    assign no_idle = (bytes_sent >= 60 && bytes_sent < 130);

    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_fire) begin
                // hold the current word
            end
            else if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
                in_valid <= 1'b1;
                in_byte  <= pending_bytes.pop_front();
            end
            else in_valid <= 1'b0;
            out_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each accepted word with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: byte %h bv %b ae %b cd %b tot %0d st %0d last %b",
                             arg_byte, byte_valid, arg_end, cmd_done, arg_total, status, last);
            end
            else begin
                e = expected_words.pop_front();
                if (arg_byte !== e.arg_byte || byte_valid !== e.byte_valid ||
                    arg_end !== e.arg_end || cmd_done !== e.cmd_done ||
                    arg_total !== e.arg_total || status !== 3'(e.status) ||
                    last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp byte %h bv %b ae %b cd %b tot %0d st %0d last %b",
                                 e.arg_byte, e.byte_valid, e.arg_end, e.cmd_done,
                                 e.arg_total, e.status, e.last);
                        $display("         got byte %h bv %b ae %b cd %b tot %0d st %0d last %b",
                                 arg_byte, byte_valid, arg_end, cmd_done, arg_total,
                                 status, last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_MAX_LINE_LEN;
        cfg_data   = 31'd0;
        in_valid   = 1'b0;
        in_byte    = 8'd0;
        out_ready  = 1'b0;
        mismatches = 0;
        ps.ph        = PH_IDLE;
        ps.llen      = 0;
        ps.args_left = 31'd0;
        ps.bulk_left = 31'd0;
        ps.num       = 64'd0;
        ps.nflags    = 4'd0;
        ps.first_b   = 8'd0;
        ps.qm        = Q_IDLE;
        ps.held      = 16'd0;
        ps.inl_count = 21'd0;
        ps.halted    = 1'b0;
        ps.cmd_total = 31'd0;
        ps.lim_line = {11'd0, RST_MAX_LINE_LEN};
        ps.lim_args = {1'b0, RST_MAX_ARG_COUNT};
        ps.lim_bulk = {1'b0, RST_MAX_BULK_LEN};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset limits
        add_text("*3\r\n$3\r\nSET\r\n$1\r\nk\r\n$4\r\nv");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("!XY");               // trailer bytes are not checked
        void'(submit_cmd(1'b0));
        send_text("*0\r\n");
        send_text("*-5\r\n");
        send_text("*-9223372036854775808\r\n");
        send_text("*1\r\n$-0\r\n\r\n");
        send_text("\n");
        send_text("\r\n");
        send_text("set a b\r\n");
        send_text("\"a\\n\\r\\t\\b\\a\\x4f\\xg\\x4\\q\\\"\" 'it\\'s\\z' x\n");
        add_text("ab");
        add_byte(CH_NUL);              // NUL ends the line contents
        add_text("junk\"\n");
        void'(submit_cmd(1'b0));
        send_text("  \t\n");
        send_text("\"\"\n");

        random_traffic(6);
        drain_all();                   // sender pauses until all words are back

        // tightest counts, widest lines
        write_limit(CFG_MAX_LINE_LEN, 31'd1048576);
        write_limit(CFG_MAX_ARG_COUNT, 31'd1);
        write_limit(CFG_MAX_BULK_LEN, 31'd0);
        send_text("*1\r\n$0\r\nxy");
        send_text("a b\n");
        drain_all();

        // widest counts, one-byte lines
        write_limit(CFG_MAX_ARG_COUNT, 31'h7FFF_FFFF);
        write_limit(CFG_MAX_BULK_LEN, 31'h7FFF_FFFF);
        write_limit(CFG_MAX_LINE_LEN, 31'd1);
        send_text("a\n");
        send_text("\n");
        drain_all();

        // middle settings
        write_limit(CFG_MAX_LINE_LEN, 31'd40);
        write_limit(CFG_MAX_ARG_COUNT, 31'd3);
        write_limit(CFG_MAX_BULK_LEN, 31'd5);
        random_traffic(6);
        drain_all();

        // the one error the run can afford: it halts the block for good
        write_limit(CFG_MAX_LINE_LEN, 31'd8);
        case ($urandom_range(7))
            0: send_text("abcdefghij");
            1: send_text("\"ab\n");
            2: send_text("*1234567890");
            3: send_text("*x\r\n");
            4: send_text("*1\r\n$12345678901");
            5: send_text("*1\r\n:3\r\n");
            6: send_text("*1\r\n$-2\r\n");
            default: send_text("*1\nabcdefgh");
        endcase
        repeat (10) add_byte(8'($urandom_range(0, 255)));
        void'(submit_cmd(1'b0));
        drain_all();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> resp_request_deframer.f
rtl/rrd_pkg.sv
rtl/rrd_core.sv
rtl/rrd_queue.sv
rtl/resp_request_deframer.sv
rtl/rrd_checker.sv
bench/tb_resp_request_deframer.sv
